FILE: hdl/i2c_master_byte_engine_assert.svh
// assertion macros for the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hdl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

	// bus command codes
	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_WAIT  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	localparam int          PHASE_TICKS_RESET = 10;
	localparam logic [2:0]  LAST_WRITE_BIT    = 3'd7;
	localparam logic [7:0]  MSB_MASK          = 8'h80;

	// one classified tick as it travels from front to back
	typedef struct packed {
		logic       is_cmd;
		cmd_t       command;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_level;
	} tick_t;

endpackage

`default_nettype wire

FILE: hdl/i2cm_front.sv
`default_nettype none

module i2cm_front (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [15:0]   s_tdata,
	input  wire logic [3:0]    s_tuser,
	input  wire logic          q_full,
	output logic               push_valid,
	output i2cm_pkg::tick_t    push_item
);
	import i2cm_pkg::*;

	logic [2:0] raw_cmd;

	assign raw_cmd    = s_tuser[3:1];
	assign s_tready   = !q_full;
	assign push_valid = s_tvalid;

	// codes above read byte are dropped here, the back never sees them as commands
	always_comb begin
		push_item.is_cmd    = s_tuser[0] && (raw_cmd <= CMD_READ);
		push_item.command   = cmd_t'(raw_cmd);
		push_item.tx_byte   = s_tdata[7:0];
		push_item.send_ack  = s_tdata[8];
		push_item.sda_level = s_tdata[9];
	end

endmodule

`default_nettype wire

FILE: hdl/i2cm_queue.sv
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire i2cm_pkg::tick_t push_item,
	output logic               full,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output i2cm_pkg::tick_t    pop_item
);
	import i2cm_pkg::*;

	tick_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`ASSERT_NEVER(q_count_range, clk, arst_n, count_q == 2'd3)
	`ASSERT_AT(q_ptr_track, clk, arst_n, (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))

endmodule

`default_nettype wire

FILE: hdl/i2cm_back.sv
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cm_back #(
	parameter int TICK_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            phase_ticks_we,
	input  wire logic [15:0]     phase_ticks,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire i2cm_pkg::tick_t pop_item,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [15:0]          m_tdata
);
	import i2cm_pkg::*;

	localparam int TW = TICK_BITS + 1;
	localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;
	localparam logic [CW-1:0] CAP = CW'({TICK_BITS{1'b1}});

	// bus drives for a phase: {scl, sda}
	function automatic logic [1:0] drive_f(
		input cmd_t       cmd,
		input logic [2:0] ph,
		input logic [3:0] bitn,
		input logic [7:0] shift,
		input logic       ack,
		input logic       scl,
		input logic       sda
	);
		logic       b;
		logic [1:0] d;
		b = shift[LAST_WRITE_BIT - bitn[2:0]];
		d = {scl, sda};
		unique case (cmd)
			CMD_START: begin
				if (ph == 3'd1) d = {scl, 1'b1};
				else if (ph == 3'd2) d = 2'b11;
				else if (ph == 3'd3) d = 2'b10;
				else d = 2'b00;
			end
			CMD_STOP: begin
				if (ph == 3'd1) d = {1'b0, sda};
				else if (ph == 3'd2) d = 2'b00;
				else if (ph == 3'd3) d = 2'b10;
				else d = 2'b11;
			end
			CMD_WRITE: begin
				if (ph == 3'd1) d = {1'b0, b};
				else if (ph == 3'd2) d = {1'b1, b};
				else d = {1'b0, (bitn[2:0] == LAST_WRITE_BIT) ? 1'b1 : b};
			end
			CMD_WAIT: begin
				d = {(ph == 3'd2), 1'b1};
			end
			CMD_READ: begin
				if (!bitn[3]) d = {(ph == 3'd1), 1'b1};
				else d = {(ph == 3'd2), !ack};
			end
			default: d = {scl, sda};
		endcase
		return d;
	endfunction

	function automatic logic [2:0] phases_f(input cmd_t cmd, input logic [3:0] bitn);
		logic [2:0] n;
		case (cmd)
			CMD_START, CMD_STOP: n = 3'd4;
			CMD_WRITE, CMD_WAIT: n = 3'd3;
			default:             n = bitn[3] ? 3'd3 : 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] bits_f(input cmd_t cmd);
		logic [3:0] n;
		case (cmd)
			CMD_WRITE: n = 4'd8;
			CMD_READ:  n = 4'd9;
			default:   n = 4'd1;
		endcase
		return n;
	endfunction

	logic [TICK_BITS-1:0] limit_q;
	logic [CW-1:0]        cfg_ext;
	logic [TICK_BITS-1:0] limit_d;

	logic [2:0]           phase_q, phase_d;
	cmd_t                 cmd_q, cmd_d;
	logic [3:0]           bit_q, bit_d;
	logic [TICK_BITS-1:0] tick_q, tick_d;
	logic [7:0]           shift_q, shift_d;
	logic                 ack_q, ack_d;
	logic                 scl_q, scl_d;
	logic                 sda_q, sda_d;
	logic                 nack_q, nack_d;
	logic [7:0]           rx_q, rx_d;
	logic                 done_d;
	logic [TW-1:0]        tick_inc;
	logic                 pop;
	logic                 m_tvalid_q;
	logic [15:0]          m_tdata_q;

	// zero acts as one, wide values clamp to the counter range
	assign cfg_ext = CW'(phase_ticks);
	always_comb begin
		if (cfg_ext == '0) limit_d = TICK_BITS'(1);
		else if (cfg_ext > CAP) limit_d = TICK_BITS'(CAP);
		else limit_d = TICK_BITS'(cfg_ext);
	end

	assign pop_ready = !m_tvalid_q || m_tready;
	assign pop       = pop_valid && pop_ready;
	assign tick_inc  = {1'b0, tick_q} + TW'(1);

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		nack_d  = nack_q;
		rx_d    = rx_q;
		done_d  = 1'b0;
		if (phase_q == 3'd0) begin
			if (pop_item.is_cmd) begin
				cmd_d   = pop_item.command;
				bit_d   = 4'd0;
				phase_d = 3'd1;
				tick_d  = '0;
				if (pop_item.command == CMD_WRITE) begin
					shift_d = pop_item.tx_byte;
				end
				if (pop_item.command == CMD_READ) begin
					shift_d = 8'd0;
					ack_d   = pop_item.send_ack;
				end
				{scl_d, sda_d} = drive_f(cmd_d, phase_d, bit_d, shift_d, ack_d, scl_q, sda_q);
			end
		end else if (tick_inc >= {1'b0, limit_q}) begin
			tick_d = '0;
			// sampling points: ack slot of wait, high half of each read bit
			if (cmd_q == CMD_WAIT && phase_q == 3'd2) begin
				nack_d = pop_item.sda_level;
			end else if (cmd_q == CMD_READ && !bit_q[3] && phase_q == 3'd1) begin
				shift_d = {shift_q[6:0], pop_item.sda_level};
			end
			if (phase_q < phases_f(cmd_q, bit_q)) begin
				phase_d = phase_q + 3'd1;
				{scl_d, sda_d} = drive_f(cmd_q, phase_d, bit_q, shift_d, ack_q, scl_q, sda_q);
			end else if (bit_q + 4'd1 < bits_f(cmd_q)) begin
				bit_d   = bit_q + 4'd1;
				phase_d = 3'd1;
				{scl_d, sda_d} = drive_f(cmd_q, phase_d, bit_d, shift_d, ack_q, scl_q, sda_q);
			end else begin
				phase_d = 3'd0;
				done_d  = 1'b1;
				if (cmd_q == CMD_READ) begin
					rx_d  = shift_d;
					sda_d = 1'b1;
				end
			end
		end else begin
			tick_d = tick_inc[TICK_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= TICK_BITS'(PHASE_TICKS_RESET);
			phase_q    <= 3'd0;
			cmd_q      <= CMD_START;
			bit_q      <= 4'd0;
			tick_q     <= '0;
			shift_q    <= 8'd0;
			ack_q      <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			nack_q     <= 1'b0;
			rx_q       <= 8'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (phase_ticks_we) begin
				limit_q <= limit_d;
			end
			if (pop) begin
				phase_q <= phase_d;
				cmd_q   <= cmd_d;
				bit_q   <= bit_d;
				tick_q  <= tick_d;
				shift_q <= shift_d;
				ack_q   <= ack_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				nack_q  <= nack_d;
				rx_q    <= rx_d;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata_q <= {3'b000, nack_d, rx_d, done_d, (phase_d != 3'd0), sda_d, scl_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_NEVER(bk_phase_range, clk, arst_n, phase_q > 3'd4)
	`ASSERT_NEVER(bk_bit_range, clk, arst_n, bit_q > 4'd8)
	`ASSERT_AT(bk_done_not_busy, clk, arst_n, (pop && done_d) |=> (m_tdata_q[2] == 1'b0))
	`ASSERT_AT(bk_idle_tick_zero, clk, arst_n, (phase_q == 3'd0) |-> (tick_q == '0))

endmodule

`default_nettype wire

FILE: hdl/i2c_master_byte_engine.sv
//  channel   dir   signals                          contents
//  s_        in    s_tvalid s_tready s_tdata s_tuser one bus tick with optional command
//  m_        out   m_tvalid m_tready m_tdata         bus drives and status after that tick
//  cfg       in    phase_ticks_we phase_ticks        ticks per scl/sda phase
//
//  one request a cycle sustained while m_tready does not stall the output: each tick is one registered engine step
//  result path after the accepting edge: queue entry, then engine register
//  a two-entry queue separates the classifier from the engine, the result sits in an
//  output register, so s_tready only drops once both queue entries are held
//  reset: drives released, no command active, phase length 10 ticks, rx byte and nack 0
//  m_tready low holds the result and the engine state; nothing is dropped or repeated
`default_nettype none

module i2c_master_byte_engine #(
	parameter int TICK_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write, no read-back
	input  wire logic        phase_ticks_we,
	input  wire logic [15:0] phase_ticks,
	// input ticks
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_level[9], zero pad
	input  wire logic [3:0]  s_tuser,   // cmd_valid[0], command[3:1]
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // scl_release[0], sda_release[1], busy_res[2],
	                                    // done_res[3], rx_byte[11:4], nack_seen[12], zero pad
);
	import i2cm_pkg::*;

	tick_t push_item;
	tick_t pop_item;
	logic  push_valid;
	logic  q_full;
	logic  pop_valid;
	logic  pop_ready;

	// front: accept and classify each tick
	i2cm_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	// short queue between classifier and engine
	i2cm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back: phase sequencer, bit shifter and output register
	i2cm_back #(
		.TICK_BITS (TICK_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.phase_ticks_we (phase_ticks_we),
		.phase_ticks    (phase_ticks),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_item       (pop_item),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule

`default_nettype wire
